// ===== rtl/ddft_pkg.sv =====
// Shared constants, types and the arctangent table for the direct DFT block.
// Used by ddft_cordic and direct_dft_mag_phase_unit; has no dependencies.
package ddft_pkg;

  localparam int MAX_POINTS_DEF = 64;
  localparam int STORE_DEPTH    = 64;
  localparam int ADDR_W         = 6;
  localparam int CNT_W          = 7;
  localparam int SAMPLE_W       = 16;
  localparam int TW_W           = 16;
  localparam int PROD_W         = 32;
  localparam int ACC_W          = 38;
  localparam int RE_W           = 23;
  localparam int MAG_W          = 22;
  localparam int PH_W           = 16;
  localparam int SQ_W           = 46;
  localparam int CW             = 46;
  localparam int ZW             = 34;
  localparam int CORDIC_STEPS   = 30;
  localparam int STEP_W         = 5;
  localparam int SQRT_STEPS     = 23;
  localparam int GAIN_Q30       = 652032874;

  typedef struct packed {
    logic start;
    logic vec;
  } cordic_ctl_t;

  // arctangent of 2^-i in 2^32 turn units
  function automatic logic [31:0] atan_turn(input logic [STEP_W-1:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

// ===== rtl/ddft_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module ddft_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/ddft_cordic.sv =====
// Iterative CORDIC, one micro-rotation per cycle, rotation or vectoring mode.
// Depends on ddft_pkg (widths, step count, arctangent table, control struct).
module ddft_cordic (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  ddft_pkg::cordic_ctl_t        ctl_i,
  input  logic signed [ddft_pkg::CW-1:0] x_i,
  input  logic signed [ddft_pkg::CW-1:0] y_i,
  input  logic signed [ddft_pkg::ZW-1:0] z_i,
  output logic                         done_o,
  output logic signed [ddft_pkg::CW-1:0] x_o,
  output logic signed [ddft_pkg::CW-1:0] y_o,
  output logic signed [ddft_pkg::ZW-1:0] z_o
);

  logic signed [ddft_pkg::CW-1:0] x_q, y_q, dx, dy;
  logic signed [ddft_pkg::ZW-1:0] z_q, ang;
  logic [ddft_pkg::STEP_W-1:0]    i_q;
  logic                           run_q, done_q, vec_q, sel;

  always_comb begin
    dx  = y_q >>> i_q;
    dy  = x_q >>> i_q;
    ang = signed'({2'b00, ddft_pkg::atan_turn(i_q)});
    // same micro-rotation for "z not negative" in rotation and "y not positive" in vectoring
    sel = vec_q ? (y_q <= 0) : (z_q >= 0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      i_q    <= '0;
      vec_q  <= 1'b0;
    end else begin
      done_q <= run_q && !ctl_i.start &&
                (i_q == ddft_pkg::STEP_W'(ddft_pkg::CORDIC_STEPS - 1));
      if (ctl_i.start) begin
        run_q <= 1'b1;
        i_q   <= '0;
        vec_q <= ctl_i.vec;
      end else if (run_q) begin
        i_q <= i_q + 1'b1;
        if (i_q == ddft_pkg::STEP_W'(ddft_pkg::CORDIC_STEPS - 1)) begin
          run_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      x_q <= x_i;
      y_q <= y_i;
      z_q <= z_i;
    end else if (run_q) begin
      if (sel) begin
        x_q <= x_q - dx;
        y_q <= y_q + dy;
        z_q <= z_q - ang;
      end else begin
        x_q <= x_q + dx;
        y_q <= y_q - dy;
        z_q <= z_q + ang;
      end
    end
  end

  assign done_o = done_q;
  assign x_o    = x_q;
  assign y_o    = y_q;
  assign z_o    = z_q;

endmodule

// ===== rtl/direct_dft_mag_phase_unit.sv =====
// Direct DFT with magnitude and phase: top level, sequencer and datapath.
// Depends on ddft_pkg, ddft_ram (sample and twiddle stores) and ddft_cordic.
//
//  channel  | dir | tdata                          | tuser      | tlast
//  s_axis   | in  | sample                         | -          | last_sample
//  m_axis   | out | bin_index,real,imag,mag,phase  | overflowed | last_bin
//
// Loading writes each accepted sample to the sample store. A block of N samples
// then runs the reciprocal divider, twiddle generation on the shared CORDIC,
// and per bin a multiply-accumulate (one sample and one twiddle memory read
// per cycle) plus magnitude and phase, the phase CORDIC being the longer of
// the two, and the bin output, which is held until it is taken.
// Sample input is stalled from the block end until the last bin is taken;
// each bin waits for its result to drain.
// Reset clears the sequencer and counters; the stores need no clearing.
module direct_dft_mag_phase_unit #(
  parameter int MAX_POINTS = ddft_pkg::MAX_POINTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] sample
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [5:0] bin_index, [28:6] real_part, [51:29] imag_part, [73:52] magnitude,
  // [89:74] phase_angle, [95:90] zero
  output logic [95:0] m_axis_tdata,
  output logic        m_axis_tuser,   // [0] overflowed
  output logic        m_axis_tlast
);

  localparam int AW = ddft_pkg::ADDR_W;
  localparam int NW = ddft_pkg::CNT_W;

  typedef enum logic [8:0] {
    S_LOAD  = 9'b000000001,
    S_DIV   = 9'b000000010,
    S_TWGO  = 9'b000000100,
    S_TWWT  = 9'b000001000,
    S_MAC   = 9'b000010000,
    S_SQ    = 9'b000100000,
    S_SUM   = 9'b001000000,
    S_POST  = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  logic          in_acc, out_acc;
  logic [NW-1:0] cnt_q, n_pts_q, ni_q;
  logic          cut_q;
  logic [7:0]    rem_q, div_t, racc_q, racc_t;
  logic [32:0]   quo_q;
  logic [5:0]    div_i_q;
  logic          div_ge;
  logic [31:0]   ang_q, ang_plus, ang_f;
  logic [AW-1:0] k_q, k2_q, m_q;
  logic [NW-1:0] k2_t;
  logic          neg_q, v1_q, v2_q;

  logic signed [ddft_pkg::SAMPLE_W-1:0] s_rd;
  logic [2*ddft_pkg::TW_W-1:0]          tw_rd, tw_wdata;
  logic signed [ddft_pkg::TW_W-1:0]     c_rd, sn_rd, c_new, s_new;
  logic signed [ddft_pkg::PROD_W-1:0]   pc_q, ps_q;
  logic signed [ddft_pkg::ACC_W-1:0]    acc_c_q, acc_s_q, re_full, im_full;
  logic signed [ddft_pkg::RE_W-1:0]     re_q, im_q;
  logic signed [2*ddft_pkg::RE_W-1:0]   re2_full, im2_full;
  logic [ddft_pkg::SQ_W-1:0]            re2_q, im2_q, srem_q, sr_q, sbit_q, stry;
  logic [4:0]                           sq_i_q;
  logic [31:0]                          zsum;

  ddft_pkg::cordic_ctl_t              cctl;
  logic signed [ddft_pkg::CW-1:0]     cx0, cy0, cx, cy, cxr, cyr, rex;
  logic signed [ddft_pkg::ZW-1:0]     cz0, cz;
  logic                               cdone;

  logic [ddft_pkg::MAG_W-1:0] o_mag_q;
  logic [ddft_pkg::PH_W-1:0]  o_ph_q;
  logic [AW-1:0]              o_bin_q;
  logic [ddft_pkg::RE_W-1:0]  o_re_q, o_im_q;
  logic                       o_last_q, m_last;

  function automatic logic signed [ddft_pkg::TW_W-1:0] q30_to_q15(
    input logic signed [ddft_pkg::CW-1:0] v
  );
    logic signed [ddft_pkg::CW-1:0] r;
    r = (v + ddft_pkg::CW'(16384)) >>> 15;
    if (r > ddft_pkg::CW'(32767)) begin
      r = ddft_pkg::CW'(32767);
    end else if (r < -ddft_pkg::CW'(32768)) begin
      r = -ddft_pkg::CW'(32768);
    end
    return r[ddft_pkg::TW_W-1:0];
  endfunction

  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (state_q == S_LOAD);
  assign m_axis_tvalid = (state_q == S_OUT);
  assign m_last        = ({1'b0, m_q} == n_pts_q - 1'b1);

  // stores
  ddft_ram #(.WIDTH(ddft_pkg::SAMPLE_W), .DEPTH(ddft_pkg::STORE_DEPTH)) u_samples (
    .clk_i   (clk_i),
    .we_i    (in_acc),
    .waddr_i (cnt_q[AW-1:0]),
    .wdata_i (s_axis_tdata),
    .raddr_i (ni_q[AW-1:0]),
    .rdata_o (s_rd)
  );

  assign tw_wdata = {s_new, c_new};

  ddft_ram #(.WIDTH(2*ddft_pkg::TW_W), .DEPTH(ddft_pkg::STORE_DEPTH)) u_twiddles (
    .clk_i   (clk_i),
    .we_i    ((state_q == S_TWWT) && cdone),
    .waddr_i (k_q),
    .wdata_i (tw_wdata),
    .raddr_i (k2_q),
    .rdata_o (tw_rd)
  );

  assign c_rd  = tw_rd[ddft_pkg::TW_W-1:0];
  assign sn_rd = tw_rd[2*ddft_pkg::TW_W-1:ddft_pkg::TW_W];

  ddft_cordic u_cordic (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (cctl),
    .x_i    (cx0),
    .y_i    (cy0),
    .z_i    (cz0),
    .done_o (cdone),
    .x_o    (cx),
    .y_o    (cy),
    .z_o    (cz)
  );

  always_comb begin
    div_t    = {rem_q[6:0], (div_i_q == 6'd32)};
    div_ge   = (div_t >= {1'b0, n_pts_q});
    ang_plus = ang_q + 32'h4000_0000;
    ang_f    = ang_plus[31] ? (ang_q ^ 32'h8000_0000) : ang_q;
    racc_t   = racc_q + {1'b0, quo_q[32] ? 7'd0 : rem_q[6:0]};
    k2_t     = {1'b0, k2_q} + {1'b0, m_q};
    cxr      = neg_q ? -cx : cx;
    cyr      = neg_q ? -cy : cy;
    c_new    = q30_to_q15(cxr);
    s_new    = q30_to_q15(cyr);
    re_full  = (acc_c_q + ddft_pkg::ACC_W'(16384)) >>> 15;
    im_full  = (ddft_pkg::ACC_W'(16384) - acc_s_q) >>> 15;
    re2_full = re_q * re_q;
    im2_full = im_q * im_q;
    stry     = sr_q + sbit_q;
    zsum     = cz[31:0] + 32'h0000_8000;
    rex      = ddft_pkg::CW'(re_q) <<< 20;

    cctl = '0;
    cx0  = ddft_pkg::CW'(ddft_pkg::GAIN_Q30);
    cy0  = '0;
    cz0  = ddft_pkg::ZW'(signed'(ang_f));
    if (state_q == S_TWGO) begin
      cctl.start = 1'b1;
    end else if (state_q == S_SUM) begin
      cctl.start = 1'b1;
      cctl.vec   = 1'b1;
      // pre-rotate by a half turn for the left half-plane
      if (re_q < 0) begin
        cx0 = -rex;
        cy0 = -(ddft_pkg::CW'(im_q) <<< 20);
        cz0 = ddft_pkg::ZW'(34'sh0_8000_0000);
      end else begin
        cx0 = rex;
        cy0 = ddft_pkg::CW'(im_q) <<< 20;
        cz0 = '0;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_LOAD: begin
        if (in_acc && (s_axis_tlast || (cnt_q + 1'b1 == NW'(MAX_POINTS)))) begin
          state_d = S_DIV;
        end
      end
      S_DIV:  if (div_i_q == 6'd0) state_d = S_TWGO;
      S_TWGO: state_d = S_TWWT;
      S_TWWT: begin
        if (cdone) begin
          state_d = ({1'b0, k_q} == n_pts_q - 1'b1) ? S_MAC : S_TWGO;
        end
      end
      S_MAC:  if (ni_q == n_pts_q && !v1_q && !v2_q) state_d = S_SQ;
      S_SQ:   state_d = S_SUM;
      S_SUM:  state_d = S_POST;
      S_POST: if (cdone) state_d = S_OUT;
      S_OUT: begin
        if (out_acc) begin
          state_d = m_last ? S_LOAD : S_MAC;
        end
      end
      default: state_d = S_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
      cnt_q   <= '0;
      n_pts_q <= NW'(1);
      cut_q   <= 1'b0;
      div_i_q <= '0;
      k_q     <= '0;
      m_q     <= '0;
      ni_q    <= '0;
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      sq_i_q  <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_LOAD: begin
          if (in_acc) begin
            if (state_d == S_DIV) begin
              cnt_q   <= '0;
              n_pts_q <= cnt_q + 1'b1;
              cut_q   <= !s_axis_tlast;
              div_i_q <= 6'd32;
              k_q     <= '0;
              m_q     <= '0;
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        S_DIV: begin
          if (div_i_q != 6'd0) div_i_q <= div_i_q - 1'b1;
        end
        S_TWWT: begin
          if (cdone) k_q <= k_q + 1'b1;
        end
        S_MAC: begin
          v1_q <= (ni_q != n_pts_q);
          v2_q <= v1_q;
          if (ni_q != n_pts_q) ni_q <= ni_q + 1'b1;
        end
        S_SUM: sq_i_q <= '0;
        S_POST: begin
          if (sq_i_q != 5'(ddft_pkg::SQRT_STEPS)) sq_i_q <= sq_i_q + 1'b1;
        end
        S_OUT: begin
          if (out_acc && !m_last) m_q <= m_q + 1'b1;
        end
        default: ;
      endcase
      if (state_d == S_MAC && state_q != S_MAC) begin
        ni_q <= '0;
        v1_q <= 1'b0;
        v2_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      S_LOAD: begin
        rem_q <= '0;
        quo_q <= '0;
      end
      S_DIV: begin
        // restoring division of 2^32 by the block length, one quotient bit a cycle
        rem_q <= div_ge ? (div_t - {1'b0, n_pts_q}) : div_t;
        quo_q <= {quo_q[31:0], div_ge};
        ang_q  <= '0;
        racc_q <= {2'b00, n_pts_q[NW-1:1]};
      end
      S_TWGO: neg_q <= ang_plus[31];
      S_TWWT: begin
        if (cdone) begin
          // advance round(k*2^32/N) by quotient and remainder
          if (racc_t >= {1'b0, n_pts_q}) begin
            racc_q <= racc_t - {1'b0, n_pts_q};
            ang_q  <= ang_q + quo_q[31:0] + 32'd1;
          end else begin
            racc_q <= racc_t;
            ang_q  <= ang_q + quo_q[31:0];
          end
        end
      end
      S_MAC: begin
        if (ni_q != n_pts_q) begin
          k2_q <= (k2_t >= n_pts_q) ? AW'(k2_t - n_pts_q) : k2_t[AW-1:0];
        end
        pc_q <= s_rd * c_rd;
        ps_q <= s_rd * sn_rd;
        if (v2_q) begin
          acc_c_q <= acc_c_q + ddft_pkg::ACC_W'(pc_q);
          acc_s_q <= acc_s_q + ddft_pkg::ACC_W'(ps_q);
        end
        re_q <= re_full[ddft_pkg::RE_W-1:0];
        im_q <= im_full[ddft_pkg::RE_W-1:0];
      end
      S_SQ: begin
        re2_q <= re2_full[ddft_pkg::SQ_W-1:0];
        im2_q <= im2_full[ddft_pkg::SQ_W-1:0];
      end
      S_SUM: begin
        srem_q <= re2_q + im2_q;
        sr_q   <= '0;
        sbit_q <= ddft_pkg::SQ_W'(1) << 44;
      end
      S_POST: begin
        if (sq_i_q != 5'(ddft_pkg::SQRT_STEPS)) begin
          if (srem_q >= stry) begin
            srem_q <= srem_q - stry;
            sr_q   <= (sr_q >> 1) + sbit_q;
          end else begin
            sr_q <= sr_q >> 1;
          end
          sbit_q <= sbit_q >> 2;
        end
        if (cdone) begin
          o_bin_q  <= m_q;
          o_re_q   <= re_q;
          o_im_q   <= im_q;
          o_last_q <= m_last;
          // leftover remainder is v - r*r: round half up
          o_mag_q  <= (srem_q > sr_q) ? ddft_pkg::MAG_W'(sr_q + 1'b1)
                                      : sr_q[ddft_pkg::MAG_W-1:0];
          o_ph_q   <= (re_q == 0 && im_q == 0) ? '0 : zsum[31:16];
        end
      end
      default: ;
    endcase
    if (state_d == S_MAC && state_q != S_MAC) begin
      k2_q    <= '0;
      acc_c_q <= '0;
      acc_s_q <= '0;
    end
  end

  assign m_axis_tdata = {6'd0, o_ph_q, o_mag_q, o_im_q, o_re_q, o_bin_q};
  assign m_axis_tuser = cut_q;
  assign m_axis_tlast = o_last_q;

`ifndef NO_ASSERTIONS
  a_sides_apart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input taken while a bin is pending");
  a_cordic_done_place: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cdone |-> (state_q == S_TWWT || state_q == S_POST))
    else $error("CORDIC finished outside a waiting state");
  a_issue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MAC) |-> (ni_q <= n_pts_q))
    else $error("MAC issued past block length");
  a_block_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) |-> (n_pts_q != '0 && n_pts_q <= NW'(MAX_POINTS)))
    else $error("block length out of range");
`endif

endmodule
